[rtl/lpsp_pkg.sv]
package lpsp_pkg;

    localparam int DEF_BLOCKS       = 12;
    localparam int DEF_CHANNELS     = 32;
    localparam int DEF_SYNC_RUN     = 6;
    localparam int DEF_HEADER_BYTES = 42;

    localparam logic [15:0] FLAG_WORD_RESET = 16'hFFEE;
    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;

    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_TRAILER = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  block_index;
        logic [4:0]  channel_index;
        logic [15:0] block_flag;
        logic [15:0] azimuth;
        logic [15:0] distance;
        logic [7:0]  reflectivity;
        logic [31:0] timestamp;
        logic [15:0] factory_word;
        logic        last;
    } t_rec;

endpackage

[rtl/lidar_packet_stream_parser.sv]
// Parses a raw lidar capture byte stream, one byte per cycle while the result queue has
// room, into point, trailer and end-of-capture records. Each accepted byte passes through
// one input register and is decoded combinationally into a three-entry result queue; the
// byte waits in the input register whenever the queue holds two or more results, and a
// byte can yield two records (a final point or trailer plus the end record).
// A packet starts at a run of SYNC_RUN 0xFF bytes whose bytes HEADER_BYTES and
// HEADER_BYTES+1 match the configured flag word; after a failed match the next
// SYNC_RUN-1 bytes are skipped. A byte's results are registered into the queue when it
// is decoded, and the record at the queue head is offered at the output.
module lidar_packet_stream_parser #(
    parameter int BLOCKS       = lpsp_pkg::DEF_BLOCKS,
    parameter int CHANNELS     = lpsp_pkg::DEF_CHANNELS,
    parameter int SYNC_RUN     = lpsp_pkg::DEF_SYNC_RUN,
    parameter int HEADER_BYTES = lpsp_pkg::DEF_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_capture,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_record_kind,
    output logic [3:0]  o_block_index,
    output logic [4:0]  o_channel_index,
    output logic [15:0] o_block_flag,
    output logic [15:0] o_azimuth,
    output logic [15:0] o_distance,
    output logic [7:0]  o_reflectivity,
    output logic [31:0] o_timestamp,
    output logic [15:0] o_factory_word,
    output logic        o_last
);
    import lpsp_pkg::*;

    localparam int HIST_LEN    = HEADER_BYTES + 1;
    localparam int BLOCK_BYTES = 4 + 3 * CHANNELS;
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int BLK_W       = $clog2(BLOCKS + 1);
    localparam int BLANK_W     = $clog2(SYNC_RUN + 1);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] PH_DIST_LO = 2'd0;
    localparam logic [1:0] PH_DIST_HI = 2'd1;
    localparam logic [1:0] PH_REFL    = 2'd2;

    logic [15:0]         r_flag_word;

    logic                r_in_vld;
    logic [7:0]          r_data;
    logic                r_eoc;

    logic [HIST_LEN-1:0] r_hist,  n_hist;
    logic [BLANK_W-1:0]  r_blank, n_blank;
    logic                r_pkt,   n_pkt;
    logic [OFF_W-1:0]    r_off,   n_off;
    logic [1:0]          r_phase, n_phase;
    logic [BLK_W-1:0]    r_blk,   n_blk;
    logic [4:0]          r_ch,    n_ch;
    logic [15:0]         r_flag,  n_flag;
    logic [15:0]         r_az,    n_az;
    logic [23:0]         r_part,  n_part;

    t_rec                r_q [QUEUE_DEPTH];
    t_rec                n_q [QUEUE_DEPTH];
    logic [CNT_W-1:0]    r_cnt,   n_cnt;

    logic                w_go;
    logic                w_pop;
    logic                w_sync;
    logic [15:0]         w_word;
    logic                w_a_vld;
    t_rec                w_a_rec;
    t_rec                w_end_rec;
    logic                w_clear;
    logic [CNT_W-1:0]    w_npush;
    logic [CNT_W-1:0]    w_base;

    assign w_go       = r_in_vld && (r_cnt <= CNT_W'(1));
    assign o_in_ready = !r_in_vld || w_go;
    assign o_out_valid = (r_cnt != '0);
    assign w_pop      = o_out_valid && i_out_ready;

    assign w_sync = &r_hist[HIST_LEN-1 -: SYNC_RUN];
    assign w_word = {r_part[7:0], r_data};

    // Byte decode
    always_comb begin
        n_hist  = r_hist;
        n_blank = r_blank;
        n_pkt   = r_pkt;
        n_off   = r_off;
        n_phase = r_phase;
        n_blk   = r_blk;
        n_ch    = r_ch;
        n_flag  = r_flag;
        n_az    = r_az;
        n_part  = r_part;
        w_a_vld = 1'b0;
        w_a_rec = '0;
        w_clear = r_eoc;

        if (r_pkt) begin
            if (r_blk < BLK_W'(BLOCKS)) begin
                if (r_off == OFF_W'(0)) begin
                    n_flag = {r_data, 8'h00};
                end else if (r_off == OFF_W'(1)) begin
                    n_flag = {r_flag[15:8], r_data};
                end else if (r_off == OFF_W'(2)) begin
                    n_az = {8'h00, r_data};
                end else if (r_off == OFF_W'(3)) begin
                    n_az    = {r_data, r_az[7:0]};
                    n_phase = PH_DIST_LO;
                end else begin
                    case (r_phase)
                        PH_DIST_LO: begin
                            n_part  = {16'h0000, r_data};
                            n_phase = PH_DIST_HI;
                        end
                        PH_DIST_HI: begin
                            n_part  = {8'h00, r_data, r_part[7:0]};
                            n_phase = PH_REFL;
                        end
                        default: begin
                            w_a_vld               = 1'b1;
                            w_a_rec.kind          = KIND_POINT;
                            w_a_rec.block_index   = 4'(r_blk);
                            w_a_rec.channel_index = r_ch;
                            w_a_rec.block_flag    = r_flag;
                            w_a_rec.azimuth       = r_az;
                            w_a_rec.distance      = r_part[15:0];
                            w_a_rec.reflectivity  = r_data;
                            n_ch    = r_ch + 5'd1;
                            n_phase = PH_DIST_LO;
                        end
                    endcase
                end
                if (r_off == OFF_W'(BLOCK_BYTES - 1)) begin
                    n_off = '0;
                    n_blk = r_blk + BLK_W'(1);
                    n_ch  = '0;
                end else begin
                    n_off = r_off + OFF_W'(1);
                end
            end else begin
                n_off = r_off + OFF_W'(1);
                if (r_off == OFF_W'(0)) begin
                    n_part = {16'h0000, r_data};
                end else if (r_off == OFF_W'(1)) begin
                    n_part = {8'h00, r_data, r_part[7:0]};
                end else if (r_off == OFF_W'(2)) begin
                    n_part = {r_data, r_part[15:0]};
                end else if (r_off == OFF_W'(3)) begin
                    n_flag = {r_data, r_part[23:16]};
                    n_az   = r_part[15:0];
                end else if (r_off == OFF_W'(4)) begin
                    n_part = {16'h0000, r_data};
                end else begin
                    w_a_vld              = 1'b1;
                    w_a_rec.kind         = KIND_TRAILER;
                    w_a_rec.timestamp    = {r_flag, r_az};
                    w_a_rec.factory_word = {r_part[7:0], r_data};
                    w_clear              = 1'b1;
                end
            end
        end else begin
            if (r_blank != '0) begin
                n_blank = r_blank - BLANK_W'(1);
            end else if (w_sync && (w_word != r_flag_word)) begin
                n_blank = BLANK_W'(SYNC_RUN - 1);
            end
            if ((r_blank == '0) && w_sync && (w_word == r_flag_word)) begin
                n_hist  = '0;
                n_blank = '0;
                n_pkt   = 1'b1;
                n_blk   = '0;
                n_ch    = '0;
                n_flag  = w_word;
                n_az    = '0;
                n_off   = OFF_W'(2);
                n_part  = '0;
            end else begin
                n_hist = {r_hist[HIST_LEN-2:0], (r_data == SYNC_BYTE)};
                n_part = {16'h0000, r_data};
            end
        end

        if (w_clear) begin
            n_hist  = '0;
            n_blank = '0;
            n_pkt   = 1'b0;
            n_off   = '0;
            n_phase = PH_DIST_LO;
            n_blk   = '0;
            n_ch    = '0;
            n_flag  = '0;
            n_az    = '0;
            n_part  = '0;
        end
    end

    // Result queue
    always_comb begin
        w_end_rec      = '0;
        w_end_rec.kind = KIND_END;
        w_end_rec.last = 1'b1;
        w_npush = CNT_W'(w_a_vld) + CNT_W'(r_eoc);
        w_base  = r_cnt - CNT_W'(w_pop);
        n_q     = r_q;
        if (w_pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_q[k] = r_q[k+1];
            end
        end
        if (w_go) begin
            if (w_a_vld) begin
                n_q[w_base[IDX_W-1:0]]      = w_a_rec;
                n_q[w_base[IDX_W-1:0]].last = !r_eoc;
                if (r_eoc) begin
                    n_q[w_base[IDX_W-1:0] + IDX_W'(1)] = w_end_rec;
                end
            end else if (r_eoc) begin
                n_q[w_base[IDX_W-1:0]] = w_end_rec;
            end
            n_cnt = w_base + w_npush;
        end else begin
            n_cnt = w_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_word <= FLAG_WORD_RESET;
            r_in_vld    <= 1'b0;
            r_hist      <= '0;
            r_blank     <= '0;
            r_pkt       <= 1'b0;
            r_off       <= '0;
            r_phase     <= PH_DIST_LO;
            r_blk       <= '0;
            r_ch        <= '0;
            r_flag      <= '0;
            r_az        <= '0;
            r_part      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_flag_word <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_go) begin
                r_hist  <= n_hist;
                r_blank <= n_blank;
                r_pkt   <= n_pkt;
                r_off   <= n_off;
                r_phase <= n_phase;
                r_blk   <= n_blk;
                r_ch    <= n_ch;
                r_flag  <= n_flag;
                r_az    <= n_az;
                r_part  <= n_part;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_data_byte;
            r_eoc  <= i_end_of_capture;
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            r_q[k] <= n_q[k];
        end
    end

    assign o_record_kind   = r_q[0].kind;
    assign o_block_index   = r_q[0].block_index;
    assign o_channel_index = r_q[0].channel_index;
    assign o_block_flag    = r_q[0].block_flag;
    assign o_azimuth       = r_q[0].azimuth;
    assign o_distance      = r_q[0].distance;
    assign o_reflectivity  = r_q[0].reflectivity;
    assign o_timestamp     = r_q[0].timestamp;
    assign o_factory_word  = r_q[0].factory_word;
    assign o_last          = r_q[0].last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_eoc_leaves_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_eoc) |=> (!r_pkt && (r_blank == '0) && (r_hist == '0)))
        else $error("end of capture did not clear stream state");

    a_blk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt |-> (r_blk <= BLK_W'(BLOCKS)))
        else $error("block counter past trailer");

    a_go_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_cnt <= CNT_W'(QUEUE_DEPTH)) && (r_cnt != '0 || !$past(w_a_vld || r_eoc)))
        else $error("decoded results lost");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_record_kind == KIND_POINT || o_record_kind == KIND_TRAILER ||
                         o_record_kind == KIND_END))
        else $error("bad record kind at output");

endmodule
